FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IBCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define IBCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IBCA_ASSERT(lbl, prop, msg)
`define IBCA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/ibca_pkg.sv
// Types, constants and register codes of the IMU bias calibration block.
`default_nettype none

package ibca_pkg;

  localparam int unsigned Axes     = 6;
  localparam int unsigned AxisW    = 16;
  localparam int unsigned SumW     = 32;
  localparam int unsigned CntW     = 16;
  localparam int unsigned GravW    = 15;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned AxisIdxW = $clog2(Axes);
  localparam int unsigned DivStepW = $clog2(SumW);

  localparam logic [AxisIdxW-1:0] LastAxis = AxisIdxW'(Axes - 1);

  localparam logic [CfgIdxW-1:0] RegSampleCount   = 1'b0;
  localparam logic [CfgIdxW-1:0] RegGravityOffset = 1'b1;

  localparam logic [CntW-1:0]  SampleCountRst = 16'd100;
  localparam logic [GravW-1:0] GravOffsetRst  = 15'd1025;

  localparam logic FuncCalib = 1'b0;
  localparam logic FuncMeas  = 1'b1;

  typedef struct packed {
    logic              func;
    logic signed [15:0] raw_gyro_x;
    logic signed [15:0] raw_gyro_y;
    logic signed [15:0] raw_gyro_z;
    logic signed [15:0] raw_accel_x;
    logic signed [15:0] raw_accel_y;
    logic signed [15:0] raw_accel_z;
  } in_item_t;

  typedef struct packed {
    logic              calib_done;
    logic signed [15:0] body_gyro_x;
    logic signed [15:0] body_gyro_y;
    logic signed [15:0] body_gyro_z;
    logic signed [15:0] body_accel_x;
    logic signed [15:0] body_accel_y;
    logic signed [15:0] body_accel_z;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic acc;
    logic meas;
    logic div_start;
    logic bias_store;
    logic done_load;
  } dp_cmd_t;

  typedef struct packed {
    logic last_sample;
    logic out_free;
    logic div_busy;
    logic div_done;
    logic idx_last;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/ibca_if.sv
// Valid/ready channel interfaces for input and result items.
`default_nettype none

interface ibca_in_if import ibca_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ibca_out_if import ibca_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ibca_div.sv
// Restoring divider, one quotient bit per cycle, unsigned sum by sample count.
`default_nettype none

module ibca_div import ibca_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SumW-1:0] dividend_i,
  input  logic [CntW-1:0] divisor_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [SumW-1:0] quot_o
);

  logic [CntW-1:0]     rem_q, rem_d;
  logic [SumW-1:0]     quot_q, quot_d;
  logic [CntW-1:0]     dvsr_q;
  logic [DivStepW-1:0] step_q, step_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW:0]       trial;
  logic                fits;

  assign trial = {rem_q, quot_q[SumW-1]} - {1'b0, dvsr_q};
  assign fits  = ~trial[CntW];

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the shifted-out bit is zero
      rem_d  = fits ? trial[CntW-1:0] : {rem_q[CntW-2:0], quot_q[SumW-1]};
      quot_d = {quot_q[SumW-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == DivStepW'(SumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      dvsr_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

FILE: rtl/ibca_datapath.sv
// Datapath: config registers, sums, biases, divider and output register.
`default_nettype none

module ibca_datapath import ibca_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  in_item_t            in_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output out_item_t           out_data_o,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o
);

  logic [CntW-1:0]     sample_count_q;
  logic [GravW-1:0]    grav_q;
  logic [SumW-1:0]     sums_q [Axes];
  logic [AxisW-1:0]    bias_q [Axes];
  logic [CntW-1:0]     cnt_q;
  logic [AxisIdxW-1:0] idx_q;
  logic                sign_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic [AxisW-1:0] raw [Axes];
  logic [AxisW-1:0] d   [Axes];
  logic [CntW-1:0]  taken;
  logic [CntW-1:0]  target;
  logic [SumW-1:0]  sum_sel;
  logic [SumW-1:0]  sum_mag;
  logic [SumW-1:0]  quot;
  logic [AxisW-1:0] bias_val;
  logic             div_busy;
  logic             div_done;

  assign raw[0] = in_data_i.raw_gyro_x;
  assign raw[1] = in_data_i.raw_gyro_y;
  assign raw[2] = in_data_i.raw_gyro_z;
  assign raw[3] = in_data_i.raw_accel_x;
  assign raw[4] = in_data_i.raw_accel_y;
  assign raw[5] = in_data_i.raw_accel_z;

  always_comb begin
    for (int i = 0; i < Axes; i++) begin
      d[i] = raw[i] - bias_q[i];
    end
  end

  // a sample count of zero behaves as one
  assign taken  = cnt_q + 1'b1;
  assign target = (sample_count_q == '0) ? CntW'(1) : sample_count_q;

  assign sum_sel  = sums_q[idx_q];
  assign sum_mag  = sum_sel[SumW-1] ? (SumW'(0) - sum_sel) : sum_sel;
  assign bias_val = sign_q ? (AxisW'(0) - quot[AxisW-1:0]) : quot[AxisW-1:0];

  ibca_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_mag),
    .divisor_i  (cnt_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= SampleCountRst;
      grav_q         <= GravOffsetRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSampleCount:   sample_count_q <= cfg_data_i;
        RegGravityOffset: grav_q         <= cfg_data_i[GravW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Axes; i++) begin
        sums_q[i] <= '0;
        bias_q[i] <= '0;
      end
      cnt_q  <= '0;
      idx_q  <= '0;
      sign_q <= 1'b0;
    end else begin
      if (cmd_i.acc) begin
        for (int i = 0; i < Axes; i++) begin
          sums_q[i] <= sums_q[i] + {{(SumW-AxisW){raw[i][AxisW-1]}}, raw[i]};
        end
        cnt_q <= taken;
        idx_q <= '0;
      end
      if (cmd_i.div_start) begin
        sign_q <= sum_sel[SumW-1];
      end
      if (cmd_i.bias_store) begin
        bias_q[idx_q] <= bias_val;
        sums_q[idx_q] <= '0;
        idx_q         <= idx_q + 1'b1;
      end
      if (cmd_i.done_load) begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.meas || cmd_i.done_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.meas) begin
      out_q.calib_done   <= 1'b0;
      out_q.body_gyro_x  <= d[1];
      out_q.body_gyro_y  <= d[0];
      out_q.body_gyro_z  <= AxisW'(0) - d[2];
      out_q.body_accel_x <= d[4] + {1'b0, grav_q};
      out_q.body_accel_y <= d[3];
      out_q.body_accel_z <= AxisW'(0) - d[5];
    end else if (cmd_i.done_load) begin
      // done flag set, all body axes zero
      out_q <= {1'b1, {($bits(out_item_t)-1){1'b0}}};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.last_sample = (taken >= target);
  assign sts_o.out_free    = ~out_valid_q | out_ready_i;
  assign sts_o.div_busy    = div_busy;
  assign sts_o.div_done    = div_done;
  assign sts_o.idx_last    = (idx_q == LastAxis);

endmodule

`default_nettype wire

FILE: rtl/ibca_ctrl.sv
// Controller: accepts items and sequences the six bias divisions.
`default_nettype none

`include "assert_macros.svh"

module ibca_ctrl import ibca_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_func_i,
  output logic    in_ready_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        // output slot must be free so a measurement request can land
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          if (in_func_i == FuncMeas) begin
            cmd_o.meas = 1'b1;
          end else begin
            cmd_o.acc = 1'b1;
            if (sts_i.last_sample) begin
              state_d = ST_DIV_LOAD;
            end
          end
        end
      end
      ST_DIV_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (sts_i.div_done) begin
          cmd_o.bias_store = 1'b1;
          state_d          = sts_i.idx_last ? ST_DONE : ST_DIV_LOAD;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.done_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `IBCA_ASSERT(a_div_start_busy, cmd_o.div_start |=> sts_i.div_busy, "divider not busy after start")
  `IBCA_ASSERT(a_busy_in_run, sts_i.div_busy |-> state_q == ST_DIV_RUN, "divider busy outside run")
  `IBCA_ASSERT_ALWAYS(a_load_free, (cmd_o.done_load || cmd_o.meas) |-> sts_i.out_free, "output overwritten")

endmodule

`default_nettype wire

FILE: rtl/imu_bias_calibrate_align_top.sv
// Top level: IMU bias calibration and axis alignment.
// Measurement request: result registered the cycle after accept; one item per cycle
// if the output is free. Calibration request not finishing a run: no result.
// Finishing request: six serial divisions on the shared restoring divider, each axis
// loaded, divided and stored in turn, then the done result once the output is free.
// Reset clears sums, count, biases and output valid and loads the register defaults.
`default_nettype none

`include "assert_macros.svh"

module imu_bias_calibrate_align_top import ibca_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ibca_in_if.sink             in_i,
  ibca_out_if.source          out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;
  logic    final_req;

  ibca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.data.func),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ibca_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign in_i.ready = in_ready;

  assign final_req = in_i.valid && in_ready && (in_i.data.func == FuncCalib) && sts.last_sample;

  // a finishing calibration request blocks further input until the biases are in
  `IBCA_ASSERT(a_final_blocks, final_req |=> !in_ready, "input taken during division")

endmodule

`default_nettype wire

FILE: verif/tb_imu_bias_calibrate_align_top.sv
// Testbench for the IMU bias calibration and axis alignment top level.
`default_nettype none

module tb_imu_bias_calibrate_align_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ibca_pkg::*;

  localparam int unsigned SettleCycles = 250;   // idle wait in quiesce after the results drain
  localparam int unsigned DrainLimit   = 5000;
  localparam int unsigned RandPhases   = 12;
  localparam int unsigned PhaseItems   = 100;
  localparam int unsigned LongRunItems = 40;
  localparam logic [15:0] AxisMin      = 16'h8000;
  localparam logic [15:0] AxisMax      = 16'h7fff;

  // Tracks sums, count and biases, and queues the result each request should produce.
  class calib_align_predictor;
    logic signed [SumW-1:0] acc_sum [Axes];
    logic [AxisW-1:0]       bias [Axes];
    logic [CntW-1:0]        n_summed;
    logic [CntW-1:0]        target_count;
    logic [GravW-1:0]       grav_offset;
    out_item_t              expected_results [$];
    int unsigned            n_fail;
    int unsigned            n_done;
    int unsigned            n_meas;

    function new();
      for (int i = 0; i < Axes; i++) begin
        acc_sum[i] = '0;
        bias[i]    = '0;
      end
      n_summed     = '0;
      target_count = SampleCountRst;
      grav_offset  = GravOffsetRst;
      n_fail       = 0;
      n_done       = 0;
      n_meas       = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegSampleCount:   target_count = val;
        RegGravityOffset: grav_offset  = val[GravW-1:0];
        default: ;
      endcase
    endfunction

    function void accept_sample(in_item_t s);
      logic [AxisW-1:0] raw [Axes];
      logic [AxisW-1:0] diff [Axes];
      logic [CntW-1:0]  limit;
      logic [CntW-1:0]  summed;
      int               sum_v;
      int               div_v;
      int               quo;
      out_item_t        r;
      raw[0] = s.raw_gyro_x;
      raw[1] = s.raw_gyro_y;
      raw[2] = s.raw_gyro_z;
      raw[3] = s.raw_accel_x;
      raw[4] = s.raw_accel_y;
      raw[5] = s.raw_accel_z;
      r = '0;
      if (s.func == FuncCalib) begin
        // a count of zero behaves as one
        limit = (target_count == '0) ? CntW'(1) : target_count;
        for (int i = 0; i < Axes; i++)
          acc_sum[i] = acc_sum[i] + {{(SumW-AxisW){raw[i][AxisW-1]}}, raw[i]};
        summed = n_summed + 1'b1;
        if (summed < limit) begin
          n_summed = summed;
          return;
        end
        for (int i = 0; i < Axes; i++) begin
          sum_v      = acc_sum[i];
          div_v      = summed;
          quo        = sum_v / div_v;   // truncates toward zero
          bias[i]    = quo[AxisW-1:0];
          acc_sum[i] = '0;
        end
        n_summed     = '0;
        r.calib_done = 1'b1;
      end else begin
        for (int i = 0; i < Axes; i++)
          diff[i] = raw[i] - bias[i];
        r.body_gyro_x  = diff[1];
        r.body_gyro_y  = diff[0];
        r.body_gyro_z  = AxisW'(0) - diff[2];
        r.body_accel_x = diff[4] + AxisW'(grav_offset);
        r.body_accel_y = diff[3];
        r.body_accel_z = AxisW'(0) - diff[5];
      end
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [AxisW-1:0] exp_v, logic [AxisW-1:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
        n_fail++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: calib_done %0b", got.calib_done);
        n_fail++;
        return;
      end
      e = expected_results.pop_front();
      if (e.calib_done) n_done++;
      else n_meas++;
      compare_field("calib_done",   AxisW'(e.calib_done), AxisW'(got.calib_done));
      compare_field("body_gyro_x",  e.body_gyro_x,  got.body_gyro_x);
      compare_field("body_gyro_y",  e.body_gyro_y,  got.body_gyro_y);
      compare_field("body_gyro_z",  e.body_gyro_z,  got.body_gyro_z);
      compare_field("body_accel_x", e.body_accel_x, got.body_accel_x);
      compare_field("body_accel_y", e.body_accel_y, got.body_accel_y);
      compare_field("body_accel_z", e.body_accel_z, got.body_accel_z);
    endfunction

    function void drop_leftovers();
      if (expected_results.size() != 0) begin
        $error("%0d expected results never arrived", expected_results.size());
        n_fail++;
        expected_results.delete();
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  ibca_in_if  req_if ();
  ibca_out_if res_if ();

  calib_align_predictor pred = new();
  int unsigned n_sent;
  int unsigned n_cfg;

  imu_bias_calibrate_align_top u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (req_if),
    .out_o     (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("imu_bias_calibrate_align_top test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      pred.check_result(res_if.data);
  end

  // Result side backpressure: free-running, random, mostly-ready and periodic stretches.
  initial begin
    int unsigned mode;
    int unsigned len;
    int unsigned k;
    res_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(8, 64);
      for (k = 0; k < len; k++) begin
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          2: res_if.ready <= ($urandom_range(0, 3) != 0);
          default: res_if.ready <= ((k % 8) > 4);
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic in_item_t make_sample(logic func, int gx, int gy, int gz,
                                           int ax, int ay, int az);
    in_item_t s;
    s.func        = func;
    s.raw_gyro_x  = 16'(gx);
    s.raw_gyro_y  = 16'(gy);
    s.raw_gyro_z  = 16'(gz);
    s.raw_accel_x = 16'(ax);
    s.raw_accel_y = 16'(ay);
    s.raw_accel_z = 16'(az);
    return s;
  endfunction

  function automatic logic [15:0] pick_axis(bit extremes);
    if (extremes) begin
      case ($urandom_range(0, 2))
        0: return AxisMin;
        1: return AxisMax;
        default: return 16'($urandom);
      endcase
    end
    case ($urandom_range(0, 9))
      0: return AxisMin;
      1: return AxisMax;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_sample(logic func, bit extremes);
    in_item_t s;
    s.func        = func;
    s.raw_gyro_x  = pick_axis(extremes);
    s.raw_gyro_y  = pick_axis(extremes);
    s.raw_gyro_z  = pick_axis(extremes);
    s.raw_accel_x = pick_axis(extremes);
    s.raw_accel_y = pick_axis(extremes);
    s.raw_accel_z = pick_axis(extremes);
    return s;
  endfunction

  task automatic push_sample(in_item_t s);
    req_if.valid <= 1'b1;
    req_if.data  <= s;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pred.accept_sample(s);
    n_sent++;
  endtask

  task automatic wait_results_clear();
    int unsigned w;
    req_if.valid <= 1'b0;
    @(posedge clk);
    w = 0;
    while (pred.expected_results.size() != 0 && w < DrainLimit) begin
      @(posedge clk);
      w++;
    end
    pred.drop_leftovers();
  endtask

  // A calibration request that produces no result may still be in flight.
  task automatic quiesce();
    wait_results_clear();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    pred.write_reg(idx, val);
    n_cfg++;
    @(posedge clk);
  endtask

  task automatic stream_samples(int unsigned count, int unsigned calib_pct,
                                int unsigned max_gap, bit extremes, bit allow_pause);
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        if (allow_pause && $urandom_range(0, 29) == 0) begin
          wait_results_clear();
        end else begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, max_gap);
          if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
      burst_left--;
      push_sample(rand_sample(($urandom_range(0, 99) < calib_pct) ? FuncCalib : FuncMeas,
                              extremes));
    end
  endtask

  initial begin
    logic [CfgDataW-1:0] cnt_v;
    logic [CfgDataW-1:0] grav_v;
    n_sent = 0;
    n_cfg  = 0;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= RegSampleCount;
    cfg_data     <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset biases are zero; gravity default wraps accel x at full scale
    push_sample(make_sample(FuncMeas, 32767, 32767, 32767, 32767, 32767, 32767));
    push_sample(make_sample(FuncMeas, -32768, -32768, -32768, -32768, -32768, -32768));
    push_sample(make_sample(FuncMeas, 0, 0, 0, 0, 0, 0));
    quiesce();

    // single-sample run: bias equals the sample
    write_reg(RegSampleCount, 16'd1);
    push_sample(make_sample(FuncCalib, -32768, 32767, 1, -1, 0, 12345));
    push_sample(make_sample(FuncMeas, 32767, 32767, 32767, 32767, 32767, 32767));
    push_sample(make_sample(FuncMeas, -32768, -32768, -32768, -32768, -32768, -32768));
    push_sample(make_sample(FuncMeas, 0, 0, 0, 0, 0, 0));
    quiesce();

    // zero count behaves as one
    write_reg(RegSampleCount, 16'd0);
    push_sample(make_sample(FuncCalib, 100, -200, 300, -400, 500, -600));
    push_sample(make_sample(FuncMeas, 0, 0, 0, 0, 0, 0));
    quiesce();

    // measurement mid-run, then count lowered below samples taken
    write_reg(RegSampleCount, 16'd3);
    write_reg(RegGravityOffset, 16'd32767);
    push_sample(make_sample(FuncCalib, -4, 5, -32768, 32767, 7, -7));
    push_sample(make_sample(FuncCalib, -3, 5, -32768, 32767, 7, -8));
    push_sample(make_sample(FuncMeas, 1234, -1234, 32767, -32768, 4321, -1));
    quiesce();
    write_reg(RegSampleCount, 16'd1);
    push_sample(make_sample(FuncCalib, 0, 5, -32768, 32767, 8, -9));
    push_sample(make_sample(FuncMeas, 1000, 1000, 1000, 1000, 1000, 1000));
    quiesce();
    write_reg(RegGravityOffset, 16'd0);
    push_sample(make_sample(FuncMeas, -32768, -32768, -32768, -32768, -32768, -32768));
    quiesce();

    // maximum count with extreme samples, then cut short by lowering the count
    write_reg(RegSampleCount, 16'd65535);
    write_reg(RegGravityOffset, 16'd1025);
    stream_samples(LongRunItems, 100, 3, 1'b1, 1'b0);
    quiesce();
    write_reg(RegSampleCount, 16'd1);
    push_sample(rand_sample(FuncCalib, 1'b1));
    push_sample(rand_sample(FuncMeas, 1'b0));
    quiesce();

    for (int unsigned p = 0; p < RandPhases; p++) begin
      case ($urandom_range(0, 9))
        0:       cnt_v = 16'd0;
        1, 2:    cnt_v = 16'd1;
        3, 4:    cnt_v = 16'd2;
        5, 6, 7: cnt_v = 16'($urandom_range(3, 8));
        default: cnt_v = 16'($urandom_range(9, 40));
      endcase
      case ($urandom_range(0, 4))
        0:       grav_v = 16'd0;
        1:       grav_v = 16'd32767;
        2:       grav_v = 16'd1025;
        default: grav_v = 16'($urandom_range(0, 32767));
      endcase
      write_reg(RegSampleCount, cnt_v);
      write_reg(RegGravityOffset, grav_v);
      stream_samples(PhaseItems, $urandom_range(30, 80), 8, 1'b0, 1'b1);
      quiesce();
    end

    $display("Sent %0d requests over %0d register writes, including a long extreme-value run.",
             n_sent, n_cfg);
    $display("Checked %0d finished calibrations and %0d measurement results.",
             pred.n_done, pred.n_meas);
    if (pred.n_fail == 0)
      $display("imu_bias_calibrate_align_top test passed");
    else
      $display("imu_bias_calibrate_align_top test failed");
    $finish;
  end

endmodule

`default_nettype wire
